// File: design/ssqe_pkg.sv
// Shared types, constants and the microcode table of the servo query engine.
`timescale 1ns / 1ps
package ssqe_pkg;

  // Input operations and commands
  localparam logic OP_REQUEST = 1'b0;
  localparam logic OP_RX_BYTE = 1'b1;

  localparam logic [1:0] CMD_CLEAR   = 2'd0;
  localparam logic [1:0] CMD_RD_ENC  = 2'd1;
  localparam logic [1:0] CMD_RD_WORD = 2'd2;
  localparam logic [1:0] CMD_UNUSED  = 2'd3;

  // Result kinds and verdict codes
  localparam logic KIND_TX      = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  localparam logic [1:0] VST_OK        = 2'd0;
  localparam logic [1:0] VST_CRC_BAD   = 2'd1;
  localparam logic [1:0] VST_PARAM_BAD = 2'd2;
  localparam logic [1:0] VST_DEV_ERR   = 2'd3;

  // Frame and CRC constants
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'h1021;
  localparam logic [7:0]  STATUS_OK     = 8'h80;
  localparam logic [7:0]  HDR_SHORT     = 8'h24;
  localparam logic [7:0]  HDR_LONG      = 8'h28;
  localparam logic [7:0]  CODE_CLEAR    = 8'h1F;
  localparam logic [7:0]  CODE_RD_ENC   = 8'h62;
  localparam logic [7:0]  CODE_RD_WORD  = 8'h11;
  localparam logic [7:0]  PARAM_CLEAR   = 8'h02;
  localparam logic [7:0]  PARAM_RD_ENC  = 8'h01;
  localparam logic [7:0]  BYTE_ZERO     = 8'h00;

  // Reply layout: index of the CRC high byte for each command
  localparam logic [4:0] RX_CRCH_CLEAR = 5'd6;
  localparam logic [4:0] RX_CRCH_ENC   = 5'd14;
  localparam logic [4:0] RX_CRCH_WORD  = 5'd8;
  localparam logic [4:0] RX_IDX_STATUS = 5'd2;

  // Microcode addresses
  localparam int UPC_W = 5;
  localparam logic [UPC_W-1:0] UA_CLEAR   = 5'd0;
  localparam logic [UPC_W-1:0] UA_RD_ENC  = 5'd8;
  localparam logic [UPC_W-1:0] UA_RD_WORD = 5'd20;
  localparam logic [UPC_W-1:0] UA_RX      = 5'd28;
  localparam logic [UPC_W-1:0] UA_VERDICT = 5'd29;

  typedef struct packed {
    logic       op;
    logic [7:0] device_id;
    logic [1:0] command;
    logic [7:0] address;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic               kind;
    logic [7:0]         tx_byte;
    logic               last;
    logic [1:0]         status;
    logic [7:0]         error_code;
    logic [31:0]        value;
    logic signed [15:0] laps;
  } out_item_t;

  typedef enum logic [2:0] {
    SRC_CONST,
    SRC_DEV,
    SRC_ADDR,
    SRC_CRC_HI,
    SRC_CRC_LO
  } src_sel_t;

  typedef struct packed {
    src_sel_t   src;
    logic [7:0] konst;
    logic       crc_en;
    logic       emit;
    logic       last;
    logic       verdict;
    logic       rx_absorb;
    logic       jmp_final;
    logic       done;
  } ucode_t;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

  // Sequencer to datapath
  typedef struct packed {
    logic   load_in;
    logic   start_req;
    logic   fire;
    ucode_t cw;
  } dp_ctl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic awaiting;
    logic rx_final;
    logic out_busy;
  } dp_stat_t;

  function automatic ucode_t uc_nop();
    ucode_t cw;
    cw = '0;
    cw.src = SRC_CONST;
    return cw;
  endfunction

  // One frame byte: emit it, fold it into the CRC unless it is a trailer byte
  function automatic ucode_t uc_emit(src_sel_t src, logic [7:0] k, logic crc_en,
                                     logic fin);
    ucode_t cw;
    cw = uc_nop();
    cw.src    = src;
    cw.konst  = k;
    cw.crc_en = crc_en;
    cw.emit   = 1'b1;
    cw.last   = fin;
    cw.done   = fin;
    return cw;
  endfunction

  // Microprogram: three frame programs, the reply byte step and the verdict step
  function automatic ucode_t ucode_rom(logic [UPC_W-1:0] pc);
    ucode_t cw;
    cw = uc_nop();
    case (pc)
      // clear encoder frame
      5'd0:  cw = uc_emit(SRC_CONST, HDR_SHORT, 1'b1, 1'b0);
      5'd1:  cw = uc_emit(SRC_DEV, BYTE_ZERO, 1'b1, 1'b0);
      5'd2:  cw = uc_emit(SRC_CONST, BYTE_ZERO, 1'b1, 1'b0);
      5'd3:  cw = uc_emit(SRC_CONST, CODE_CLEAR, 1'b1, 1'b0);
      5'd4:  cw = uc_emit(SRC_CONST, BYTE_ZERO, 1'b1, 1'b0);
      5'd5:  cw = uc_emit(SRC_CONST, PARAM_CLEAR, 1'b1, 1'b0);
      5'd6:  cw = uc_emit(SRC_CRC_HI, BYTE_ZERO, 1'b0, 1'b0);
      5'd7:  cw = uc_emit(SRC_CRC_LO, BYTE_ZERO, 1'b0, 1'b1);
      // read encoder frame
      5'd8:  cw = uc_emit(SRC_CONST, HDR_LONG, 1'b1, 1'b0);
      5'd9:  cw = uc_emit(SRC_DEV, BYTE_ZERO, 1'b1, 1'b0);
      5'd10: cw = uc_emit(SRC_CONST, BYTE_ZERO, 1'b1, 1'b0);
      5'd11: cw = uc_emit(SRC_CONST, CODE_RD_ENC, 1'b1, 1'b0);
      5'd12: cw = uc_emit(SRC_CONST, BYTE_ZERO, 1'b1, 1'b0);
      5'd13: cw = uc_emit(SRC_CONST, PARAM_RD_ENC, 1'b1, 1'b0);
      5'd14: cw = uc_emit(SRC_CONST, BYTE_ZERO, 1'b1, 1'b0);
      5'd15: cw = uc_emit(SRC_CONST, BYTE_ZERO, 1'b1, 1'b0);
      5'd16: cw = uc_emit(SRC_CONST, BYTE_ZERO, 1'b1, 1'b0);
      5'd17: cw = uc_emit(SRC_CONST, BYTE_ZERO, 1'b1, 1'b0);
      5'd18: cw = uc_emit(SRC_CRC_HI, BYTE_ZERO, 1'b0, 1'b0);
      5'd19: cw = uc_emit(SRC_CRC_LO, BYTE_ZERO, 1'b0, 1'b1);
      // read state word frame
      5'd20: cw = uc_emit(SRC_CONST, HDR_SHORT, 1'b1, 1'b0);
      5'd21: cw = uc_emit(SRC_DEV, BYTE_ZERO, 1'b1, 1'b0);
      5'd22: cw = uc_emit(SRC_CONST, BYTE_ZERO, 1'b1, 1'b0);
      5'd23: cw = uc_emit(SRC_CONST, CODE_RD_WORD, 1'b1, 1'b0);
      5'd24: cw = uc_emit(SRC_CONST, BYTE_ZERO, 1'b1, 1'b0);
      5'd25: cw = uc_emit(SRC_ADDR, BYTE_ZERO, 1'b1, 1'b0);
      5'd26: cw = uc_emit(SRC_CRC_HI, BYTE_ZERO, 1'b0, 1'b0);
      5'd27: cw = uc_emit(SRC_CRC_LO, BYTE_ZERO, 1'b0, 1'b1);
      // reply byte: absorb it, or branch to the verdict on the final byte
      5'd28: begin
        cw.rx_absorb = 1'b1;
        cw.jmp_final = 1'b1;
        cw.done      = 1'b1;
      end
      5'd29: begin
        cw.emit    = 1'b1;
        cw.verdict = 1'b1;
        cw.done    = 1'b1;
      end
      default: cw.done = 1'b1;
    endcase
    return cw;
  endfunction

endpackage

// File: design/ssqe_crc.sv
// CRC-16/CCITT-FALSE update over one byte, MSB first.
`timescale 1ns / 1ps
module ssqe_crc (
  input  logic [15:0] crc_in,
  input  logic [7:0]  byte_in,
  output logic [15:0] crc_out
);
  import ssqe_pkg::*;

  // Shift the byte through the polynomial one bit per step
  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {byte_in, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule

// File: design/ssqe_seq.sv
// Microcode sequencer: step counter, control ROM, dispatch and conditional jump.
`timescale 1ns / 1ps
module ssqe_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  ssqe_pkg::in_item_t in_data,
  output logic               in_ready,
  input  ssqe_pkg::dp_stat_t stat,
  output ssqe_pkg::dp_ctl_t  ctl
);
  import ssqe_pkg::*;

  seq_state_t       state_r, state_nxt;
  logic [UPC_W-1:0] pc_r, pc_nxt;
  ucode_t           cw;
  logic             in_fire;
  logic             start_req;
  logic             start_rx;
  logic             fire;
  logic [UPC_W-1:0] entry_pc;

  // Hold state and step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_IDLE;
      pc_r    <= UA_CLEAR;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
    end
  end

  // Dispatch new items and advance through the microprogram
  always_comb begin
    cw        = ucode_rom(pc_r);
    in_ready  = (state_r == SEQ_IDLE);
    in_fire   = in_valid & in_ready;
    start_req = in_fire & (in_data.op == OP_REQUEST) & (in_data.command != CMD_UNUSED);
    start_rx  = in_fire & (in_data.op == OP_RX_BYTE) & stat.awaiting;
    fire      = (state_r == SEQ_RUN) & ~(cw.emit & stat.out_busy);

    case (in_data.command)
      CMD_CLEAR:  entry_pc = UA_CLEAR;
      CMD_RD_ENC: entry_pc = UA_RD_ENC;
      default:    entry_pc = UA_RD_WORD;
    endcase

    state_nxt = state_r;
    pc_nxt    = pc_r;
    case (state_r)
      SEQ_IDLE: begin
        if (start_req) begin
          state_nxt = SEQ_RUN;
          pc_nxt    = entry_pc;
        end else if (start_rx) begin
          state_nxt = SEQ_RUN;
          pc_nxt    = UA_RX;
        end
      end
      SEQ_RUN: begin
        if (fire) begin
          if (cw.jmp_final && stat.rx_final) begin
            pc_nxt = UA_VERDICT;
          end else if (cw.done) begin
            state_nxt = SEQ_IDLE;
          end else begin
            pc_nxt = pc_r + 1'b1;
          end
        end
      end
      default: state_nxt = SEQ_IDLE;
    endcase

    ctl.load_in   = in_fire;
    ctl.start_req = start_req;
    ctl.fire      = fire;
    ctl.cw        = cw;
  end

endmodule

// File: design/ssqe_dp.sv
// Datapath: frame byte select, shared CRC unit, reply collection and result register.
`timescale 1ns / 1ps
module ssqe_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  ssqe_pkg::in_item_t  in_data,
  input  ssqe_pkg::dp_ctl_t   ctl,
  output ssqe_pkg::dp_stat_t  stat,
  output logic                out_valid,
  input  logic                out_ready,
  output ssqe_pkg::out_item_t out_data
);
  import ssqe_pkg::*;

  in_item_t    in_r;
  logic [15:0] tx_crc_r, tx_crc_nxt;
  logic [1:0]  pending_r, pending_nxt;
  logic        awaiting_r, awaiting_nxt;
  logic [4:0]  rx_count_r, rx_count_nxt;
  logic [15:0] rx_crc_r, rx_crc_nxt;
  logic [7:0]  status_byte_r, status_byte_nxt;
  logic        param_nz_r, param_nz_nxt;
  logic [31:0] value_r, value_nxt;
  logic [15:0] laps_r, laps_nxt;
  logic [7:0]  crc_hi_r, crc_hi_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_r, out_nxt;

  logic [15:0] crc_in;
  logic [7:0]  crc_byte_in;
  logic [15:0] crc_out;
  logic [7:0]  tx_sel;
  logic [4:0]  crch_idx;
  logic        rx_final;
  logic        absorb;
  logic        emit_go;
  out_item_t   verdict;

  ssqe_crc u_crc (
    .crc_in  (crc_in),
    .byte_in (crc_byte_in),
    .crc_out (crc_out)
  );

  // Latch the accepted item
  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      in_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_crc_r      <= CRC_INIT;
      pending_r     <= CMD_CLEAR;
      awaiting_r    <= 1'b0;
      rx_count_r    <= '0;
      rx_crc_r      <= CRC_INIT;
      status_byte_r <= '0;
      param_nz_r    <= 1'b0;
      value_r       <= '0;
      laps_r        <= '0;
      crc_hi_r      <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      tx_crc_r      <= tx_crc_nxt;
      pending_r     <= pending_nxt;
      awaiting_r    <= awaiting_nxt;
      rx_count_r    <= rx_count_nxt;
      rx_crc_r      <= rx_crc_nxt;
      status_byte_r <= status_byte_nxt;
      param_nz_r    <= param_nz_nxt;
      value_r       <= value_nxt;
      laps_r        <= laps_nxt;
      crc_hi_r      <= crc_hi_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  // Select frame byte and feed the shared CRC unit
  always_comb begin
    case (ctl.cw.src)
      SRC_CONST:  tx_sel = ctl.cw.konst;
      SRC_DEV:    tx_sel = in_r.device_id;
      SRC_ADDR:   tx_sel = in_r.address;
      SRC_CRC_HI: tx_sel = tx_crc_r[15:8];
      SRC_CRC_LO: tx_sel = tx_crc_r[7:0];
      default:    tx_sel = ctl.cw.konst;
    endcase
    crc_in      = ctl.cw.rx_absorb ? rx_crc_r : tx_crc_r;
    crc_byte_in = ctl.cw.rx_absorb ? in_r.rx_byte : tx_sel;

    case (pending_r)
      CMD_CLEAR:  crch_idx = RX_CRCH_CLEAR;
      CMD_RD_ENC: crch_idx = RX_CRCH_ENC;
      default:    crch_idx = RX_CRCH_WORD;
    endcase
    rx_final = (rx_count_r == crch_idx + 5'd1);
  end

  // Form the verdict in check order: CRC, clear parameter, device status
  always_comb begin
    verdict = '0;
    verdict.kind = KIND_VERDICT;
    if ({crc_hi_r, in_r.rx_byte} != rx_crc_r) begin
      verdict.status = VST_CRC_BAD;
    end else if (pending_r == CMD_CLEAR && param_nz_r) begin
      verdict.status = VST_PARAM_BAD;
    end else if (status_byte_r != STATUS_OK) begin
      verdict.status     = VST_DEV_ERR;
      verdict.error_code = status_byte_r;
    end else begin
      verdict.status = VST_OK;
      if (pending_r != CMD_CLEAR) begin
        verdict.value = value_r;
      end
      if (pending_r == CMD_RD_ENC) begin
        verdict.laps = laps_r;
      end
    end
  end

  // Next state of the reply collector, frame CRC and result register
  always_comb begin
    tx_crc_nxt      = tx_crc_r;
    pending_nxt     = pending_r;
    awaiting_nxt    = awaiting_r;
    rx_count_nxt    = rx_count_r;
    rx_crc_nxt      = rx_crc_r;
    status_byte_nxt = status_byte_r;
    param_nz_nxt    = param_nz_r;
    value_nxt       = value_r;
    laps_nxt        = laps_r;
    crc_hi_nxt      = crc_hi_r;
    out_nxt         = out_r;
    out_valid_nxt   = out_valid_r & ~out_ready;

    absorb  = ctl.fire & ctl.cw.rx_absorb & ~rx_final;
    emit_go = ctl.fire & ctl.cw.emit;

    // New request: restart the reply collector
    if (ctl.start_req) begin
      tx_crc_nxt      = CRC_INIT;
      pending_nxt     = in_data.command;
      awaiting_nxt    = 1'b1;
      rx_count_nxt    = '0;
      rx_crc_nxt      = CRC_INIT;
      status_byte_nxt = '0;
      param_nz_nxt    = 1'b0;
      value_nxt       = '0;
      laps_nxt        = '0;
      crc_hi_nxt      = '0;
    end

    if (ctl.fire && ctl.cw.crc_en) begin
      tx_crc_nxt = crc_out;
    end

    // Collect one reply byte
    if (absorb) begin
      rx_count_nxt = rx_count_r + 5'd1;
      if (rx_count_r < crch_idx) begin
        rx_crc_nxt = crc_out;
        if (rx_count_r == RX_IDX_STATUS) begin
          status_byte_nxt = in_r.rx_byte;
        end
        if (pending_r == CMD_CLEAR && rx_count_r inside {5'd4, 5'd5} &&
            in_r.rx_byte != BYTE_ZERO) begin
          param_nz_nxt = 1'b1;
        end
        if ((pending_r == CMD_RD_ENC && rx_count_r inside {[5'd8:5'd11]}) ||
            (pending_r == CMD_RD_WORD && rx_count_r inside {[5'd4:5'd7]})) begin
          value_nxt = {value_r[23:0], in_r.rx_byte};
        end
        if (pending_r == CMD_RD_ENC && rx_count_r inside {5'd12, 5'd13}) begin
          laps_nxt = {laps_r[7:0], in_r.rx_byte};
        end
      end else begin
        crc_hi_nxt = in_r.rx_byte;
      end
    end

    // Close the reply after the verdict
    if (ctl.fire && ctl.cw.verdict) begin
      awaiting_nxt = 1'b0;
      rx_count_nxt = '0;
      rx_crc_nxt   = CRC_INIT;
    end

    // Load the result register
    if (emit_go) begin
      out_valid_nxt = 1'b1;
      if (ctl.cw.verdict) begin
        out_nxt = verdict;
      end else begin
        out_nxt         = '0;
        out_nxt.kind    = KIND_TX;
        out_nxt.tx_byte = tx_sel;
        out_nxt.last    = ctl.cw.last;
      end
    end
  end

  assign stat.awaiting = awaiting_r;
  assign stat.rx_final = rx_final;
  assign stat.out_busy = out_valid_r & ~out_ready;
  assign out_valid     = out_valid_r;
  assign out_data      = out_r;

endmodule

// File: design/servo_serial_query_engine.sv
// Top level of the servo drive query engine: sequencer plus datapath.
`timescale 1ns / 1ps
// The accepted request is latched and the sequencer starts its frame program of 8 or 12
// bytes; each step stalls while the result register is held; in_ready is low until done.
// A reply byte runs the reply step; the final reply byte yields the verdict.
// Rate is set by the microcode step counter: one control word, one frame byte, per cycle.
// Reset (rst_n low, synchronous) idles the sequencer, drops any pending reply and
// empties the result register.
module servo_serial_query_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ssqe_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ssqe_pkg::out_item_t out_data
);
  import ssqe_pkg::*;

  dp_ctl_t  ctl;
  dp_stat_t stat;

  ssqe_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_ready (in_ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  ssqe_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .ctl       (ctl),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
